>>> sv/dpr_pkg.sv
package dpr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 12;
  localparam int unsigned KindW  = 3;
  localparam int unsigned BundleN = 4;
  localparam int unsigned BundleCntW = 3;

  localparam logic [CountW-1:0] MaxPayloadRst = 12'd400;

  localparam logic [ByteW-1:0] ChStart = 8'h24;
  localparam logic [ByteW-1:0] ChEnd   = 8'h23;
  localparam logic [ByteW-1:0] ChAck   = 8'h2B;
  localparam logic [ByteW-1:0] ChNak   = 8'h2D;
  localparam logic [ByteW-1:0] ChSeq   = 8'h3A;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD = 3'd0,
    KIND_XMIT    = 3'd1,
    KIND_ACCEPT  = 3'd2,
    KIND_REJECT  = 3'd3,
    KIND_DROP    = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_BODY = 4'b0010,
    PH_HI   = 4'b0100,
    PH_LO   = 4'b1000
  } phase_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
  } res_t;

  typedef struct packed {
    logic [BundleCntW-1:0] cnt;
    res_t [BundleN-1:0]    res;
  } bundle_t;

  // Non-hex characters count as zero.
  function automatic logic [3:0] hex_value(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] d;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end
    return d[3:0];
  endfunction

endpackage

>>> sv/dpr_parse.sv
module dpr_parse (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [dpr_pkg::ByteW-1:0]   byte_i,
  input  logic [dpr_pkg::CountW-1:0]  max_payload_i,
  output dpr_pkg::bundle_t            bundle_o
);

  dpr_pkg::phase_e              ph_q, ph_d;
  logic [dpr_pkg::ByteW-1:0]    sum_q, sum_d;
  logic [dpr_pkg::CountW-1:0]   cnt_q, cnt_d;
  logic [3:0]                   hn_q, hn_d;
  logic                         seq_q, seq_d;
  logic [dpr_pkg::ByteW-1:0]    held_q [2];
  logic                         held_we;
  logic [dpr_pkg::ByteW-1:0]    sent;

  assign sent = {hn_q, dpr_pkg::hex_value(byte_i)};
  assign held_we = (ph_q == dpr_pkg::PH_BODY) && (byte_i != dpr_pkg::ChEnd) &&
                   (cnt_q < max_payload_i) && (cnt_q < 12'd2);

  always_comb begin
    ph_d  = ph_q;
    sum_d = sum_q;
    cnt_d = cnt_q;
    hn_d  = hn_q;
    seq_d = seq_q;
    bundle_o = '0;
    unique case (ph_q)
      dpr_pkg::PH_HUNT: begin
        if (byte_i == dpr_pkg::ChStart) begin
          ph_d  = dpr_pkg::PH_BODY;
          sum_d = '0;
          cnt_d = '0;
          seq_d = 1'b0;
          hn_d  = '0;
        end
      end
      dpr_pkg::PH_BODY: begin
        if (byte_i == dpr_pkg::ChEnd) begin
          // Release bytes still held back for a short payload.
          if (cnt_q == 12'd1) begin
            bundle_o.cnt = 3'd1;
            bundle_o.res[0] = '{dpr_pkg::KIND_PAYLOAD, held_q[0]};
          end else if (cnt_q == 12'd2) begin
            bundle_o.cnt = 3'd2;
            bundle_o.res[0] = '{dpr_pkg::KIND_PAYLOAD, held_q[0]};
            bundle_o.res[1] = '{dpr_pkg::KIND_PAYLOAD, held_q[1]};
          end
          ph_d = dpr_pkg::PH_HI;
        end else if (cnt_q >= max_payload_i) begin
          bundle_o.cnt = 3'd1;
          bundle_o.res[0] = '{dpr_pkg::KIND_DROP, 8'h00};
          ph_d = dpr_pkg::PH_HUNT;
        end else begin
          sum_d = sum_q + byte_i;
          if (cnt_q == 12'd2) begin
            if (byte_i == dpr_pkg::ChSeq) begin
              seq_d = 1'b1;
            end else begin
              bundle_o.cnt = 3'd3;
              bundle_o.res[0] = '{dpr_pkg::KIND_PAYLOAD, held_q[0]};
              bundle_o.res[1] = '{dpr_pkg::KIND_PAYLOAD, held_q[1]};
              bundle_o.res[2] = '{dpr_pkg::KIND_PAYLOAD, byte_i};
            end
          end else if (cnt_q > 12'd2) begin
            bundle_o.cnt = 3'd1;
            bundle_o.res[0] = '{dpr_pkg::KIND_PAYLOAD, byte_i};
          end
          cnt_d = cnt_q + 12'd1;
        end
      end
      dpr_pkg::PH_HI: begin
        hn_d = dpr_pkg::hex_value(byte_i);
        ph_d = dpr_pkg::PH_LO;
      end
      dpr_pkg::PH_LO: begin
        if (sent == sum_q) begin
          bundle_o.res[0] = '{dpr_pkg::KIND_XMIT, dpr_pkg::ChAck};
          if (seq_q) begin
            bundle_o.cnt = 3'd4;
            bundle_o.res[1] = '{dpr_pkg::KIND_XMIT, held_q[0]};
            bundle_o.res[2] = '{dpr_pkg::KIND_XMIT, held_q[1]};
            bundle_o.res[3] = '{dpr_pkg::KIND_ACCEPT, 8'h00};
          end else begin
            bundle_o.cnt = 3'd2;
            bundle_o.res[1] = '{dpr_pkg::KIND_ACCEPT, 8'h00};
          end
        end else begin
          bundle_o.cnt = 3'd2;
          bundle_o.res[0] = '{dpr_pkg::KIND_XMIT, dpr_pkg::ChNak};
          bundle_o.res[1] = '{dpr_pkg::KIND_REJECT, 8'h00};
        end
        ph_d = dpr_pkg::PH_HUNT;
      end
      default: begin
        ph_d = dpr_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= dpr_pkg::PH_HUNT;
      sum_q <= '0;
      cnt_q <= '0;
      hn_q  <= '0;
      seq_q <= 1'b0;
    end else if (fire_i) begin
      ph_q  <= ph_d;
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      hn_q  <= hn_d;
      seq_q <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && held_we) begin
      held_q[cnt_q[0]] <= byte_i;
    end
  end

endmodule

>>> sv/debug_packet_receiver.sv
// Debugger packet receiver: takes one received character per word on the
// input channel, frames '$' payload '#' hh packets, and puts out result
// words (payload bytes, bytes to transmit, and a verdict of accepted,
// rejected or dropped), each marked last on the final word one character
// causes. A character enters the input register at the clock edge it is
// accepted and is decoded, once the buffer is free, into a small result
// buffer of up to four words, which drains one word per cycle onto the
// output channel unless the output stalls. Characters that cause zero or
// one result word therefore flow at one per cycle while the output does
// not stall; a character causing n words occupies the buffer until its n
// words have left (n is at most 4: ack, two sequence-id bytes, verdict).
// The checksum is the payload sum modulo 256; non-hex checksum digits
// count as zero. Register max_payload (byte address 0, 12 bits, reset 400)
// limits the payload length; write it only while the block is idle.
module debug_packet_receiver (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Receive channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [dpr_pkg::ByteW-1:0]  rx_byte_i,
  // Result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [dpr_pkg::KindW-1:0]  kind_o,
  output logic [dpr_pkg::ByteW-1:0]  data_o,
  output logic                       last_o,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [dpr_pkg::CountW-1:0]     max_payload_q;

  logic                           in_vld_q;
  logic [dpr_pkg::ByteW-1:0]      in_byte_q;
  logic                           in_acc;

  logic [dpr_pkg::BundleCntW-1:0] bcnt_q;
  dpr_pkg::res_t [dpr_pkg::BundleN-1:0] bres_q;
  dpr_pkg::bundle_t               bundle;
  logic                           pop;
  logic                           bnd_free;
  logic                           load;

  // Configuration: one register at byte address 0; paddr[2] selects beyond it.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {20'd0, max_payload_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= dpr_pkg::MaxPayloadRst;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      max_payload_q <= pwdata[dpr_pkg::CountW-1:0];
    end
  end

  // Result buffer drains from entry 0; a new decode may load it when it is
  // empty or its final word leaves in this cycle.
  assign pop      = out_valid_o && !out_stall_i;
  assign bnd_free = (bcnt_q == 3'd0) || ((bcnt_q == 3'd1) && pop);
  assign load     = in_vld_q && bnd_free;

  // Hold the input word while the buffer is still busy.
  assign in_stall_o = in_vld_q && !bnd_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (load) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Framing, checksum and sequence-id handling.
  dpr_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (load),
    .byte_i        (in_byte_q),
    .max_payload_i (max_payload_q),
    .bundle_o      (bundle)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= '0;
    end else if (load) begin
      bcnt_q <= bundle.cnt;
    end else if (pop) begin
      bcnt_q <= bcnt_q - 3'd1;
    end
  end

  // Advance entries toward the output on every pop that does not coincide with a load.
  always_ff @(posedge clk_i) begin
    if (load) begin
      bres_q <= bundle.res;
    end else if (pop) begin
      bres_q[0] <= bres_q[1];
      bres_q[1] <= bres_q[2];
      bres_q[2] <= bres_q[3];
    end
  end

  assign out_valid_o = (bcnt_q != 3'd0);
  assign kind_o      = bres_q[0].kind;
  assign data_o      = bres_q[0].data;
  assign last_o      = (bcnt_q == 3'd1);

endmodule

>>> bench/testbench.sv
module testbench;
  import dpr_pkg::*;

  // Bus addresses of the register map: only max_payload exists, the next
  // slot must swallow writes without effect.
  localparam logic [2:0] AddrMaxPayload = 3'd0;
  localparam logic [2:0] AddrUnmapped   = 3'd4;

  // Cycles to let a character that causes no word clear the input register
  // and the decode stage before the register is touched.
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned NumPhases    = 7;
  localparam int unsigned HoldPhase    = 1;
  localparam int unsigned MaxReports   = 20;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic             last;
  } word_t;

  // One row of the directed table. A pinned row carries its words typed in;
  // every other row is checked against the predictor.
  typedef struct {
    logic [ByteW-1:0] ch;
    bit               pinned;
    int unsigned      n;
    kind_e            k0;
    logic [ByteW-1:0] d0;
    kind_e            k1;
    logic [ByteW-1:0] d1;
  } probe_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [ByteW-1:0]   rx_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [KindW-1:0]   kind_o;
  logic [ByteW-1:0]   data_o;
  logic               last_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  debug_packet_receiver dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o     (kind_o),
    .data_o     (data_o),
    .last_o     (last_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Framer state mirrored from the accepted character stream.
  phase_e             rx_phase;
  logic [ByteW-1:0]   rx_sum;
  logic [CountW-1:0]  rx_count;
  logic [ByteW-1:0]   rx_held [2];
  logic [3:0]         rx_hi;
  logic               rx_seq;
  logic [CountW-1:0]  max_payload_q;

  word_t              awaited [$];   // words still owed by the block, oldest first
  int unsigned        fault_count;
  int unsigned        useful;        // characters the framer actually acted on
  int unsigned        send_odds;     // one-in-N chance of a sender gap; 0 = none
  int unsigned        stall_odds;    // one-in-N chance of a receiver stall burst
  logic               hold_req;

  // Empty packet, sequence-id packet with lower-case checksum, one-byte
  // packet with a non-hex digit, and a '$' taken as payload in a two-byte
  // packet. Extremes 00/FF appear both outside and inside a packet.
  probe_t directed [0:24] = '{
    '{8'h00,   1'b1, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{8'hFF,   1'b1, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{ChStart, 1'b1, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{ChEnd,   1'b1, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{8'h30,   1'b1, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{8'h30,   1'b1, 2, KIND_XMIT,    ChAck, KIND_ACCEPT,  8'h00},
    '{ChStart, 1'b1, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{8'h31,   1'b0, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{8'h32,   1'b0, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{ChSeq,   1'b0, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{8'h41,   1'b0, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{ChEnd,   1'b0, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{8'h64,   1'b0, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{8'h65,   1'b0, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{ChStart, 1'b1, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{8'hFF,   1'b0, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{ChEnd,   1'b0, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{8'h5A,   1'b0, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{8'h46,   1'b1, 2, KIND_XMIT,    ChNak, KIND_REJECT,  8'h00},
    '{ChStart, 1'b1, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{ChStart, 1'b0, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{8'h00,   1'b0, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{ChEnd,   1'b0, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{8'h32,   1'b0, 0, KIND_PAYLOAD, 8'h00, KIND_PAYLOAD, 8'h00},
    '{8'h34,   1'b1, 2, KIND_XMIT,    ChAck, KIND_ACCEPT,  8'h00}
  };

  // Free-running clock, period 20.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or loses words.
  initial begin
    #(4_000_000);
    $display("[debug_packet_receiver] ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (fault_count < MaxReports) begin
      $display("mismatch on %s at %0t: got %0h, want %0h", what, $realtime, got, want);
    end
    fault_count++;
  endtask

  function automatic logic [3:0] nibble_of(input logic [ByteW-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c[3:0];
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return 8'h30 + nib;
    return (upper ? 8'h37 : 8'h57) + nib;
  endfunction

  // Advance the framer by one accepted character and, unless the caller
  // types the words in itself, queue the words it owes.
  task automatic frame_char(input logic [ByteW-1:0] c, input bit pinned);
    word_t          batch [$];
    logic [ByteW-1:0] sent;
    case (rx_phase)
      PH_HUNT: begin
        if (c == ChStart) begin
          rx_phase = PH_BODY;
          rx_sum   = '0;
          rx_count = '0;
          rx_seq   = 1'b0;
          rx_hi    = '0;
        end
      end
      PH_BODY: begin
        if (c == ChEnd) begin
          // Flush bytes held back for a sequence id that never came.
          if (rx_count == 12'd1) begin
            batch.push_back(word_t'{KIND_PAYLOAD, rx_held[0], 1'b0});
          end else if (rx_count == 12'd2) begin
            batch.push_back(word_t'{KIND_PAYLOAD, rx_held[0], 1'b0});
            batch.push_back(word_t'{KIND_PAYLOAD, rx_held[1], 1'b0});
          end
          rx_phase = PH_HI;
        end else if (rx_count >= max_payload_q) begin
          batch.push_back(word_t'{KIND_DROP, 8'h00, 1'b0});
          rx_phase = PH_HUNT;
        end else begin
          rx_sum = rx_sum + c;
          if (rx_count < 12'd2) begin
            rx_held[rx_count[0]] = c;
          end else if (rx_count == 12'd2) begin
            if (c == ChSeq) begin
              rx_seq = 1'b1;
            end else begin
              batch.push_back(word_t'{KIND_PAYLOAD, rx_held[0], 1'b0});
              batch.push_back(word_t'{KIND_PAYLOAD, rx_held[1], 1'b0});
              batch.push_back(word_t'{KIND_PAYLOAD, c, 1'b0});
            end
          end else begin
            batch.push_back(word_t'{KIND_PAYLOAD, c, 1'b0});
          end
          rx_count = rx_count + 12'd1;
        end
      end
      PH_HI: begin
        rx_hi    = nibble_of(c);
        rx_phase = PH_LO;
      end
      default: begin
        sent = {rx_hi, nibble_of(c)};
        if (sent == rx_sum) begin
          batch.push_back(word_t'{KIND_XMIT, ChAck, 1'b0});
          if (rx_seq) begin
            batch.push_back(word_t'{KIND_XMIT, rx_held[0], 1'b0});
            batch.push_back(word_t'{KIND_XMIT, rx_held[1], 1'b0});
          end
          batch.push_back(word_t'{KIND_ACCEPT, 8'h00, 1'b0});
        end else begin
          batch.push_back(word_t'{KIND_XMIT, ChNak, 1'b0});
          batch.push_back(word_t'{KIND_REJECT, 8'h00, 1'b0});
        end
        rx_phase = PH_HUNT;
      end
    endcase
    if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
    if (!pinned) begin
      foreach (batch[i]) awaited.push_back(batch[i]);
    end
  endtask

  // Offer one character and hold it until accepted. Valid stays high on
  // return so back-to-back words need no extra edge.
  task automatic offer_char(input logic [ByteW-1:0] c, input bit pinned);
    if (send_odds != 0 && $urandom_range(send_odds - 1, 0) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= c;
    do @(posedge clk_i); while (in_stall_o);
    if (rx_phase != PH_HUNT || c == ChStart) useful++;
    frame_char(c, pinned);
  endtask

  // Drop valid, let every owed word drain, then give the pipeline time to
  // swallow any character that owes nothing.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == AddrMaxPayload) max_payload_q = value[CountW-1:0];
  endtask

  task automatic check_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrMaxPayload;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CountW-1:0] !== max_payload_q) begin
      flag_mismatch("max_payload readback", prdata, 32'(max_payload_q));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One framed packet with random content. Most are well formed; some lose
  // their trailer or carry a wrong or non-hex checksum.
  task automatic send_packet();
    int unsigned      len;
    int unsigned      mode;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] csum;
    bit               upper;
    if (max_payload_q <= 12'd12) begin
      len = $urandom_range(max_payload_q + 2, 0);
    end else if ($urandom_range(9, 0) == 0) begin
      len = $urandom_range(40, 12);
    end else begin
      len = $urandom_range(8, 0);
    end
    offer_char(ChStart, 1'b0);
    for (int i = 0; i < len; i++) begin
      do b = 8'($urandom_range(255, 0)); while (b == ChEnd);
      if (i == 2 && $urandom_range(2, 0) == 0) b = ChSeq;
      offer_char(b, 1'b0);
    end
    // Broken packet: skip the trailer, the next '$' lands in the payload.
    if ($urandom_range(9, 0) == 0) return;
    offer_char(ChEnd, 1'b0);
    mode  = $urandom_range(9, 0);
    upper = 1'($urandom_range(1, 0));
    csum  = rx_sum;
    if (mode == 7) csum = rx_sum + 8'd1 + 8'($urandom_range(254, 0));
    if (mode == 9) begin
      offer_char(8'($urandom_range(255, 0)), 1'b0);
      offer_char(8'($urandom_range(255, 0)), 1'b0);
    end else begin
      if (mode == 8) begin
        // Non-hex high digit counts as zero.
        do b = 8'($urandom_range(255, 0)); while (nibble_of(b) != 4'd0 || b == 8'h30);
      end else begin
        b = hex_char(csum[7:4], upper);
      end
      offer_char(b, 1'b0);
      offer_char(hex_char(csum[3:0], upper), 1'b0);
    end
  endtask

  // Receiver side: random stall bursts, plus one long hold-off on request
  // so the result buffer fills and the input stalls.
  initial begin : sink_stalls
    int unsigned left;
    bit          hold_done;
    left      = 0;
    hold_done = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        for (int i = 0; i < LongHold; i++) @(posedge clk_i);
        hold_done   = 1'b1;
        out_stall_i <= 1'b0;
      end else if (left != 0) begin
        left--;
        out_stall_i <= 1'b1;
      end else if (stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
        left = $urandom_range(11, 1) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Check every word taken from the block against the oldest one owed.
  always @(posedge clk_i) begin : word_check
    word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited.size() == 0) begin
        flag_mismatch("unowed word kind/data", 32'({kind_o, data_o}), 32'h0);
      end else begin
        want = awaited.pop_front();
        if (kind_o !== want.kind) flag_mismatch("kind", 32'(kind_o), 32'(want.kind));
        if (data_o !== want.data) flag_mismatch("data", 32'(data_o), 32'(want.data));
        if (last_o !== want.last) flag_mismatch("last", 32'(last_o), 32'(want.last));
      end
    end
  end

  // Main sequence: reset, directed table, register checks, random phases.
  initial begin : run
    int unsigned target;
    int unsigned plan_max [NumPhases];
    int unsigned plan_items [NumPhases];
    int unsigned plan_send [NumPhases];
    int unsigned plan_stall [NumPhases];
    plan_max   = '{1, 4095, 0, 3, 13, 2, 400};
    plan_items = '{40, 64, 16, 64, 64, 32, 48};
    plan_send  = '{4, 6, 3, 3, 5, 8, 0};
    plan_stall = '{4, 3, 6, 8, 5, 0, 0};
    plan_max[4] = $urandom_range(30, 13);

    fault_count   = 0;
    useful        = 0;
    send_odds     = 5;
    stall_odds    = 5;
    rx_phase      = PH_HUNT;
    rx_sum        = '0;
    rx_count      = '0;
    rx_held[0]    = '0;
    rx_held[1]    = '0;
    rx_hi         = '0;
    rx_seq        = 1'b0;
    max_payload_q = MaxPayloadRst;

    // Hold reset with every input at a known value.
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    rx_byte_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    hold_req   <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register must come up at its reset value.
    check_reg();

    foreach (directed[i]) begin
      offer_char(directed[i].ch, directed[i].pinned);
      if (directed[i].pinned && directed[i].n > 0) begin
        awaited.push_back(word_t'{directed[i].k0, directed[i].d0, directed[i].n == 1});
        if (directed[i].n > 1) awaited.push_back(word_t'{directed[i].k1, directed[i].d1, 1'b1});
      end
    end

    // A write past the only register must leave max_payload alone.
    quiesce();
    write_reg(AddrUnmapped, 32'h0000_0ABC);
    check_reg();

    for (int p = 0; p < NumPhases; p++) begin
      quiesce();
      write_reg(AddrMaxPayload, plan_max[p]);
      check_reg();
      send_odds  = plan_send[p];
      stall_odds = plan_stall[p];
      if (p == HoldPhase) hold_req <= 1'b1;
      target = useful + plan_items[p];
      while (useful < target) begin
        // Noise between packets: ignored while hunting.
        if ($urandom_range(3, 0) == 0) begin
          repeat ($urandom_range(3, 1)) offer_char(8'($urandom_range(255, 0)), 1'b0);
        end
        send_packet();
      end
    end

    // Drain, then give the pipeline time to show stray words.
    quiesce();
    if (fault_count == 0) begin
      $display("[debug_packet_receiver] OK");
    end else begin
      $display("[debug_packet_receiver] ERROR");
    end
    $finish;
  end

endmodule

>>> debug_packet_receiver.f
sv/dpr_pkg.sv
sv/dpr_parse.sv
sv/debug_packet_receiver.sv
bench/testbench.sv
